// ----- hw/rtl/prd_pkg.sv -----
// Shared constants and types for the PCX run-length plane decoder.
// No dependencies; imported by the top level and the sequencer of the decoder.
package prd_pkg;

  // Default sizing of the line stores and the row counter
  localparam int unsigned PRD_MAX_WIDTH  = 1024;
  localparam int unsigned PRD_MAX_HEIGHT = 65536;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_WIDTH_BITS  = 11;
  localparam int unsigned CFG_HEIGHT_BITS = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRUE_COLOR   = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2,
    CFG_UNUSED       = 2'd3
  } prd_cfg_idx_e;

  // Input operation codes
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Stream byte coding
  localparam logic [7:0] RUN_MARKER_MASK = 8'hC0;
  localparam int unsigned RUN_LEN_W      = 6;

  // Plane numbering inside one true-color line
  localparam logic [1:0] PLANE_FIRST  = 2'd0;
  localparam logic [1:0] PLANE_SECOND = 2'd1;
  localparam logic [1:0] PLANE_MERGE  = 2'd2;

  // One decoded copy, as issued by the sequencer to the stores and output stage
  typedef struct packed {
    logic go;        // a copy is processed this cycle
    logic emit;      // the copy produces a pixel
    logic wr_first;  // store the byte in the first-plane line store
    logic wr_second; // store the byte in the second-plane line store
    logic last;      // final pixel caused by the current input byte
    logic eop;       // final pixel of the picture
  } prd_step_t;

endpackage

// ----- hw/rtl/pcx_rle_plane_decoder_core.sv -----
// Top level of the PCX run-length plane decoder: sequencer, two line stores
// and the output register. Depends on prd_pkg, prd_seq and prd_line_ram.
//
//  Channel  Direction  Handshake                 Payload
//  ------   ---------  ------------------------  ---------------------------------------
//  in       in         in_valid_i / in_ready_o   op_i, data_byte_i
//  out      out        out_valid_o / out_ready_i pixel_byte_a/b/c_o, last_of_item_o,
//                                                end_of_picture_o
//  cfg      in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// Flow: an input transaction is taken when no copies are outstanding; a literal byte is
// accepted, then makes one copy; a run value byte is accepted, then makes up to N copies;
// a marker or restart is only accepted. The engine issues one copy per cycle, a pixel copy
// only when the output register has room; a merged pixel's store reads register with it.
// Reset: asynchronous, active low; clears the control registers and counters, not the pixel
// payload. Line stores are not cleared: every entry is written in the current line before it is read.
// Stalls: a held output register pauses only copies that emit pixels; plane copies
// into the line stores keep running.
module pcx_rle_plane_decoder_core import prd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = PRD_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = PRD_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            pixel_byte_a_o,
  output logic [7:0]            pixel_byte_b_o,
  output logic [7:0]            pixel_byte_c_o,
  output logic                  last_of_item_o,
  output logic                  end_of_picture_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  prd_step_t     step;
  logic [CW-1:0] addr;
  logic [7:0]    value;
  logic          tc;
  logic          out_free;
  logic          rd_en;
  logic [7:0]    first_rdata, second_rdata;

  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_a_q;
  logic       last_q, eop_q, merged_q;

  // The output register takes a new pixel when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;
  // Fetch both stored planes for a merged pixel
  assign rd_en    = step.emit && tc;

  prd_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .out_free_i  (out_free),
    .step_o      (step),
    .addr_o      (addr),
    .value_o     (value),
    .tc_o        (tc)
  );

  // First plane of the line
  prd_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (step.wr_first),
    .re_i    (rd_en),
    .addr_i  (addr),
    .wdata_i (value),
    .rdata_o (first_rdata)
  );

  // Second plane of the line
  prd_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (step.wr_second),
    .re_i    (rd_en),
    .addr_i  (addr),
    .wdata_i (value),
    .rdata_o (second_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the pixel payload until the transaction completes
  always_ff @(posedge clk_i) begin
    if (step.emit) begin
      byte_a_q <= value;
      last_q   <= step.last;
      eop_q    <= step.eop;
      merged_q <= tc;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pixel_byte_a_o   = byte_a_q;
  assign pixel_byte_b_o   = merged_q ? second_rdata : 8'd0;
  assign pixel_byte_c_o   = merged_q ? first_rdata : 8'd0;
  assign last_of_item_o   = last_q;
  assign end_of_picture_o = eop_q;

  // A pixel is only produced when the output register can take it
  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.emit |-> out_free)
    else $error("pixel issued into a full output register");

  // The picture's final pixel also closes its input byte
  a_eop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_picture_o) |-> last_of_item_o)
    else $error("end of picture without last-of-item");

  // A waiting pixel keeps its payload until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o &&
      $stable({pixel_byte_a_o, pixel_byte_b_o, pixel_byte_c_o, last_of_item_o,
               end_of_picture_o})))
    else $error("output payload changed while waiting");

endmodule

// ----- hw/rtl/prd_line_ram.sv -----
// One line store: synchronous single-write, single-read memory with a registered read port.
// Self-contained; no package needed.
module prd_line_ram #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/prd_seq.sv -----
// Decoder sequencer: configuration registers, run decoding and the copy engine
// that walks column, plane and row. Depends on prd_pkg.
module prd_seq import prd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = PRD_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = PRD_MAX_HEIGHT,
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  out_free_i,
  output prd_step_t             step_o,
  output logic [CW-1:0]         addr_o,
  output logic [7:0]            value_o,
  output logic                  tc_o
);

  logic                 tc_q, tc_d;
  logic [CW:0]          width_q, width_d;
  logic [RW:0]          height_q, height_d;
  logic                 pending_q, pending_d;
  logic [RUN_LEN_W-1:0] run_len_q, run_len_d;
  logic [RUN_LEN_W-1:0] cnt_q, cnt_d;
  logic [7:0]           value_q, value_d;
  logic [1:0]           plane_q, plane_d;
  logic [CW-1:0]        col_q, col_d;
  logic [RW-1:0]        row_q, row_d;
  logic                 fin_q, fin_d;

  logic        busy, accept, emit_now, go;
  logic [CW:0] col_inc;
  logic [RW:0] row_inc;
  logic        col_wrap, row_done, line_end, fin_new, stop;
  logic [31:0] cfg_w_raw, cfg_h_raw, cfg_w_eff, cfg_h_eff;

  // Clamp register writes to the supported picture size
  always_comb begin
    cfg_w_raw = 32'(cfg_data_i[CFG_WIDTH_BITS-1:0]);
    cfg_h_raw = 32'(cfg_data_i[CFG_HEIGHT_BITS-1:0]);
    if (cfg_w_raw == 32'd0) begin
      cfg_w_eff = 32'd1;
    end else if (cfg_w_raw > 32'(MAX_WIDTH)) begin
      cfg_w_eff = 32'(MAX_WIDTH);
    end else begin
      cfg_w_eff = cfg_w_raw;
    end
    if (cfg_h_raw == 32'd0) begin
      cfg_h_eff = 32'd1;
    end else if (cfg_h_raw > 32'(MAX_HEIGHT)) begin
      cfg_h_eff = 32'(MAX_HEIGHT);
    end else begin
      cfg_h_eff = cfg_h_raw;
    end
  end

  assign busy       = (cnt_q != '0);
  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;
  assign emit_now   = !tc_q || (plane_q == PLANE_MERGE);
  assign go         = busy && (!emit_now || out_free_i);

  assign col_inc  = {1'b0, col_q} + (CW+1)'(1);
  assign row_inc  = {1'b0, row_q} + (RW+1)'(1);
  assign col_wrap = (col_inc >= width_q);
  assign row_done = (row_inc >= height_q);
  assign line_end = col_wrap && (!tc_q || plane_q == PLANE_MERGE);
  assign fin_new  = line_end && row_done;
  // In true-color mode a run never crosses the end of a line
  assign stop     = fin_new || (line_end && tc_q) || (cnt_q == RUN_LEN_W'(1));

  always_comb begin
    tc_d      = tc_q;
    width_d   = width_q;
    height_d  = height_q;
    pending_d = pending_q;
    run_len_d = run_len_q;
    cnt_d     = cnt_q;
    value_d   = value_q;
    plane_d   = plane_q;
    col_d     = col_q;
    row_d     = row_q;
    fin_d     = fin_q;

    if (cfg_we_i && cfg_idx_i != CFG_UNUSED) begin
      unique case (prd_cfg_idx_e'(cfg_idx_i))
        CFG_TRUE_COLOR:   tc_d     = cfg_data_i[0];
        CFG_IMAGE_WIDTH:  width_d  = (CW+1)'(cfg_w_eff);
        CFG_IMAGE_HEIGHT: height_d = (RW+1)'(cfg_h_eff);
        default:          tc_d     = tc_q;
      endcase
      pending_d = 1'b0;
      run_len_d = '0;
      cnt_d     = '0;
      plane_d   = PLANE_FIRST;
      col_d     = '0;
      row_d     = '0;
      fin_d     = 1'b0;
    end else if (accept) begin
      if (op_i == OP_RESTART) begin
        pending_d = 1'b0;
        run_len_d = '0;
        plane_d   = PLANE_FIRST;
        col_d     = '0;
        row_d     = '0;
        fin_d     = 1'b0;
      end else if (!fin_q) begin
        if (pending_q) begin
          pending_d = 1'b0;
          cnt_d     = run_len_q;
          value_d   = data_byte_i;
        end else if ((data_byte_i & RUN_MARKER_MASK) == RUN_MARKER_MASK) begin
          pending_d = 1'b1;
          run_len_d = data_byte_i[RUN_LEN_W-1:0];
        end else begin
          cnt_d   = RUN_LEN_W'(1);
          value_d = data_byte_i;
        end
      end
    end else if (go) begin
      // Advance one copy
      cnt_d = stop ? '0 : cnt_q - RUN_LEN_W'(1);
      if (col_wrap) begin
        col_d = '0;
        if (tc_q && plane_q != PLANE_MERGE) begin
          plane_d = plane_q + 2'd1;
        end else begin
          plane_d = PLANE_FIRST;
          row_d   = row_inc[RW-1:0];
          fin_d   = row_done;
        end
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q      <= 1'b0;
      width_q   <= (CW+1)'(1);
      height_q  <= (RW+1)'(1);
      pending_q <= 1'b0;
      run_len_q <= '0;
      cnt_q     <= '0;
      plane_q   <= PLANE_FIRST;
      col_q     <= '0;
      row_q     <= '0;
      fin_q     <= 1'b0;
    end else begin
      tc_q      <= tc_d;
      width_q   <= width_d;
      height_q  <= height_d;
      pending_q <= pending_d;
      run_len_q <= run_len_d;
      cnt_q     <= cnt_d;
      plane_q   <= plane_d;
      col_q     <= col_d;
      row_q     <= row_d;
      fin_q     <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_comb begin
    step_o.go        = go;
    step_o.emit      = go && emit_now;
    step_o.wr_first  = go && tc_q && (plane_q == PLANE_FIRST);
    step_o.wr_second = go && tc_q && (plane_q == PLANE_SECOND);
    step_o.last      = stop;
    step_o.eop       = fin_new;
  end

  assign addr_o  = col_q;
  assign value_o = value_q;
  assign tc_o    = tc_q;

  // A finished picture has no copy in flight
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !busy)
    else $error("copy engine active after end of picture");

  // The column stays inside the configured line
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < width_q)
    else $error("column beyond line width");

  // A counted run never overlaps a pending marker
  a_run_vs_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !pending_q)
    else $error("run marker pending while copies are issued");

endmodule
